[design/mh_pkg.sv]
package mh_pkg;

    localparam int OFFSET_WIDTH    = 13;
    localparam int HEADING_WIDTH   = 9;
    localparam int ANGLE_WIDTH     = 32;
    localparam int ANGLE_TABLE_LEN = 24;

    localparam logic [ANGLE_WIDTH-1:0]   HALF_TURN   = 32'h8000_0000;
    localparam logic [HEADING_WIDTH-1:0] DEG_FULL    = 9'd360;
    localparam logic [HEADING_WIDTH-1:0] DEG_WEST    = 9'd270;
    localparam logic [HEADING_WIDTH-1:0] DEG_EAST    = 9'd90;
    localparam logic [HEADING_WIDTH-1:0] DEG_NORTH   = 9'd0;

    typedef enum logic {
        CFG_X_OFFSET = 1'b0,
        CFG_Y_OFFSET = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic                     valid;
        logic                     bypass;
        logic                     hvalid;
        logic [HEADING_WIDTH-1:0] heading;
    } ctl_t;

    function automatic logic [ANGLE_WIDTH-1:0] cordic_angle(input int stage);
        logic [ANGLE_WIDTH-1:0] angle;
        unique case (stage)
            0:  angle = 32'h2000_0000;
            1:  angle = 32'h12E4_051E;
            2:  angle = 32'h09FB_385B;
            3:  angle = 32'h0511_11D4;
            4:  angle = 32'h028B_0D43;
            5:  angle = 32'h0145_D7E1;
            6:  angle = 32'h00A2_F61E;
            7:  angle = 32'h0051_7C55;
            8:  angle = 32'h0028_BE53;
            9:  angle = 32'h0014_5F2F;
            10: angle = 32'h000A_2F98;
            11: angle = 32'h0005_17CC;
            12: angle = 32'h0002_8BE6;
            13: angle = 32'h0001_45F3;
            14: angle = 32'h0000_A2FA;
            15: angle = 32'h0000_517D;
            16: angle = 32'h0000_28BE;
            17: angle = 32'h0000_145F;
            18: angle = 32'h0000_0A30;
            19: angle = 32'h0000_0518;
            20: angle = 32'h0000_028C;
            21: angle = 32'h0000_0146;
            22: angle = 32'h0000_00A3;
            23: angle = 32'h0000_0051;
            default: angle = '0;
        endcase
        return angle;
    endfunction

endpackage

[design/mh_if.sv]
interface mh_sample_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] mag_x;
    logic signed [W-1:0] mag_y;

    modport source (output valid, output mag_x, output mag_y, input ready);
    modport sink   (input valid, input mag_x, input mag_y, output ready);
endinterface

interface mh_heading_if;
    logic       valid;
    logic       ready;
    logic [8:0] heading_deg;
    logic       heading_valid;

    modport source (output valid, output heading_deg, output heading_valid, input ready);
    modport sink   (input valid, input heading_deg, input heading_valid, output ready);
endinterface

[design/mh_front.sv]
module mh_front #(
    parameter int W  = 16,
    parameter int XW = 19
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic                                in_valid,
    input  logic signed [W-1:0]                 mag_x,
    input  logic signed [W-1:0]                 mag_y,
    input  logic signed [mh_pkg::OFFSET_WIDTH-1:0] x_offset,
    input  logic signed [mh_pkg::OFFSET_WIDTH-1:0] y_offset,
    output mh_pkg::ctl_t                        ctl_out,
    output logic signed [XW-1:0]                x_out,
    output logic signed [XW-1:0]                y_out,
    output logic [mh_pkg::ANGLE_WIDTH-1:0]      z_out
);
    import mh_pkg::*;

    localparam int AW = W + 2;

    logic signed [AW-1:0]    a;
    logic signed [AW-1:0]    b;
    logic signed [XW-1:0]    a_ext;
    logic signed [XW-1:0]    b_ext;
    logic                    flip;
    ctl_t                    ctl_next;
    ctl_t                    ctl_reg;
    logic signed [XW-1:0]    x_next;
    logic signed [XW-1:0]    y_next;
    logic [ANGLE_WIDTH-1:0]  z_next;
    logic signed [XW-1:0]    x_reg;
    logic signed [XW-1:0]    y_reg;
    logic [ANGLE_WIDTH-1:0]  z_reg;

    always_comb
    begin
        a     = AW'(x_offset) - AW'(mag_y);
        b     = AW'(mag_x) + AW'(y_offset);
        a_ext = XW'(a);
        b_ext = XW'(b);
        flip  = b < 0;

        ctl_next.valid  = in_valid;
        ctl_next.bypass = (b == 0);
        ctl_next.hvalid = !((a == 0) && (b == 0));
        if (b != 0)
        begin
            ctl_next.heading = DEG_NORTH;
        end
        else if (a > 0)
        begin
            ctl_next.heading = DEG_WEST;
        end
        else if (a < 0)
        begin
            ctl_next.heading = DEG_EAST;
        end
        else
        begin
            ctl_next.heading = DEG_NORTH;
        end

        x_next = flip ? -b_ext : b_ext;
        y_next = flip ? -a_ext : a_ext;
        z_next = flip ? HALF_TURN : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (load)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

[design/mh_cell.sv]
module mh_cell #(
    parameter int XW    = 19,
    parameter int SHIFT = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  mh_pkg::ctl_t                   ctl_in,
    input  logic signed [XW-1:0]           x_in,
    input  logic signed [XW-1:0]           y_in,
    input  logic [mh_pkg::ANGLE_WIDTH-1:0] z_in,
    output mh_pkg::ctl_t                   ctl_out,
    output logic signed [XW-1:0]           x_out,
    output logic signed [XW-1:0]           y_out,
    output logic [mh_pkg::ANGLE_WIDTH-1:0] z_out
);
    import mh_pkg::*;

    localparam logic [ANGLE_WIDTH-1:0] ANGLE = cordic_angle(SHIFT);

    logic signed [XW-1:0]   x_shift;
    logic signed [XW-1:0]   y_shift;
    logic signed [XW-1:0]   x_next;
    logic signed [XW-1:0]   y_next;
    logic [ANGLE_WIDTH-1:0] z_next;
    ctl_t                   ctl_reg;
    logic signed [XW-1:0]   x_reg;
    logic signed [XW-1:0]   y_reg;
    logic [ANGLE_WIDTH-1:0] z_reg;

    always_comb
    begin
        x_shift = x_in >>> SHIFT;
        y_shift = y_in >>> SHIFT;
        priority if (y_in > 0)
        begin
            x_next = x_in + y_shift;
            y_next = y_in - x_shift;
            z_next = z_in + ANGLE;
        end
        else if (y_in < 0)
        begin
            x_next = x_in - y_shift;
            y_next = y_in + x_shift;
            z_next = z_in - ANGLE;
        end
        else
        begin
            x_next = x_in;
            y_next = y_in;
            z_next = z_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (load)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

[design/magnetometer_heading.sv]
// Compass heading from one magnetometer sample. Each transaction on the sample
// channel yields exactly one transaction on the result channel, in order. The
// datapath is a pipeline of one input stage, CORDIC_STAGES arctangent cells and
// one output stage that scales the angle to degrees. The input stage captures a
// sample at the edge that accepts it and its result passes through the cells and
// the output stage to the result channel. A new sample can be accepted in every
// cycle unless a stalled result channel has filled the pipeline. No more than
// 24 cells are built, so larger settings behave as 24. Each stage moves on as
// soon as the stage after it is free, so empty stages close up and a stalled
// result channel only holds back the input once the whole pipeline is full. The
// offsets are to be written only while no sample is in flight.
module magnetometer_heading #(
    parameter int CORDIC_STAGES = 16,
    parameter int SAMPLE_WIDTH  = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  mh_pkg::cfg_index_t                     cfg_index,
    input  logic [mh_pkg::OFFSET_WIDTH-1:0]        cfg_wdata,
    mh_sample_if.sink                              sample,
    mh_heading_if.source                           result
);
    import mh_pkg::*;

    localparam int NS = (CORDIC_STAGES < ANGLE_TABLE_LEN) ? CORDIC_STAGES : ANGLE_TABLE_LEN;
    localparam int XW = SAMPLE_WIDTH + 3;
    localparam int PW = ANGLE_WIDTH + HEADING_WIDTH;

    logic signed [OFFSET_WIDTH-1:0] x_offset_reg;
    logic signed [OFFSET_WIDTH-1:0] y_offset_reg;

    ctl_t                   ctl   [0:NS];
    logic signed [XW-1:0]   x_pipe[0:NS];
    logic signed [XW-1:0]   y_pipe[0:NS];
    logic [ANGLE_WIDTH-1:0] z_pipe[0:NS];
    logic                   load  [0:NS+1];

    logic                     out_valid_reg;
    logic [HEADING_WIDTH-1:0] heading_reg;
    logic                     hvalid_reg;
    logic [HEADING_WIDTH-1:0] heading_next;
    logic [ANGLE_WIDTH-1:0]   neg_z;
    logic [PW-1:0]            product;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_offset_reg <= '0;
            y_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_X_OFFSET: x_offset_reg <= cfg_wdata;
                CFG_Y_OFFSET: y_offset_reg <= cfg_wdata;
            endcase
        end
    end

    assign load[NS+1] = !out_valid_reg || result.ready;

    genvar k;
    generate
        for (k = 0; k <= NS; k++)
        begin : g_load
            assign load[k] = !ctl[k].valid || load[k+1];
        end
    endgenerate

    assign sample.ready = load[0];

    mh_front #(
        .W  (SAMPLE_WIDTH),
        .XW (XW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load[0]),
        .in_valid (sample.valid),
        .mag_x    (sample.mag_x[SAMPLE_WIDTH-1:0]),
        .mag_y    (sample.mag_y[SAMPLE_WIDTH-1:0]),
        .x_offset (x_offset_reg),
        .y_offset (y_offset_reg),
        .ctl_out  (ctl[0]),
        .x_out    (x_pipe[0]),
        .y_out    (y_pipe[0]),
        .z_out    (z_pipe[0])
    );

    generate
        for (k = 0; k < NS; k++)
        begin : g_cell
            mh_cell #(
                .XW    (XW),
                .SHIFT (k)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .load    (load[k+1]),
                .ctl_in  (ctl[k]),
                .x_in    (x_pipe[k]),
                .y_in    (y_pipe[k]),
                .z_in    (z_pipe[k]),
                .ctl_out (ctl[k+1]),
                .x_out   (x_pipe[k+1]),
                .y_out   (y_pipe[k+1]),
                .z_out   (z_pipe[k+1])
            );
        end
    endgenerate

    always_comb
    begin
        neg_z   = '0 - z_pipe[NS];
        product = PW'(neg_z) * PW'(DEG_FULL);
        heading_next = ctl[NS].bypass ? ctl[NS].heading
                                      : product[PW-1:ANGLE_WIDTH];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load[NS+1])
        begin
            out_valid_reg <= ctl[NS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[NS+1])
        begin
            heading_reg <= heading_next;
            hvalid_reg  <= ctl[NS].hvalid;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.heading_deg   = heading_reg;
    assign result.heading_valid = hvalid_reg;

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (heading_reg < DEG_FULL))
        else $error("heading out of range");

    a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !hvalid_reg) |-> (heading_reg == DEG_NORTH))
        else $error("zero vector must report heading zero");

    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (out_valid_reg && ctl[0].valid && ctl[NS].valid))
        else $error("input held back while pipeline has a bubble");

    a_last_cell_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl[NS].valid && !load[NS+1]) |=> ctl[NS].valid)
        else $error("stalled item lost in last cell");

endmodule

[tb/heading_checker.sv]
module heading_checker #(
    parameter int STAGES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  mh_pkg::cfg_index_t              cfg_index,
    input  logic [mh_pkg::OFFSET_WIDTH-1:0] cfg_wdata,
    mh_sample_if                            sample,
    mh_heading_if                           result,
    output int                              mismatches,
    output int                              in_flight
);
    import mh_pkg::*;

    typedef struct packed {
        logic [HEADING_WIDTH-1:0] deg;
        logic                     ok;
    } heading_t;

    localparam logic [ANGLE_WIDTH-1:0] ATAN_STEP [ANGLE_TABLE_LEN] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    logic signed [OFFSET_WIDTH-1:0] x_off;
    logic signed [OFFSET_WIDTH-1:0] y_off;
    heading_t                       pending_headings [$];

    // The vector (b, a) is rotated onto the positive b axis; the heading is the
    // negated accumulated angle scaled from a 32-bit binary angle to degrees.
    function automatic heading_t predict_heading(input logic signed [15:0] mx,
                                                 input logic signed [15:0] my);
        longint                 a;
        longint                 b;
        longint                 x;
        longint                 y;
        longint                 nx;
        longint                 ny;
        logic [ANGLE_WIDTH-1:0] z;
        logic [63:0]            scaled;
        heading_t               r;
        a = longint'(x_off) - longint'(my);
        b = longint'(y_off) + longint'(mx);
        r.ok = 1'b1;
        r.deg = DEG_NORTH;
        if (a == 0 && b == 0)
        begin
            r.ok = 1'b0;
            return r;
        end
        if (b == 0)
        begin
            r.deg = (a > 0) ? DEG_WEST : DEG_EAST;
            return r;
        end
        x = b;
        y = a;
        z = '0;
        if (b < 0)
        begin
            x = -b;
            y = -a;
            z = HALF_TURN;
        end
        for (int i = 0; i < STAGES && i < ANGLE_TABLE_LEN; i++)
        begin
            if (y == 0)
                break;
            if (y > 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + ATAN_STEP[i];
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - ATAN_STEP[i];
            end
            x = nx;
            y = ny;
        end
        z = '0 - z;
        scaled = {32'd0, z} * 64'd360;
        r.deg = scaled[40:32];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        heading_t want;
        int       errs;
        if (!rst_n)
        begin
            x_off <= '0;
            y_off <= '0;
            pending_headings.delete();
            mismatches <= 0;
            in_flight <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_we)
            begin
                if (cfg_index == CFG_X_OFFSET)
                    x_off <= cfg_wdata;
                else if (cfg_index == CFG_Y_OFFSET)
                    y_off <= cfg_wdata;
            end
            if (sample.valid && sample.ready)
                pending_headings.push_back(predict_heading(sample.mag_x, sample.mag_y));
            if (result.valid && result.ready)
            begin
                if (pending_headings.size() == 0)
                begin
                    $error("unexpected result transaction: heading_deg %0d heading_valid %0b",
                           result.heading_deg, result.heading_valid);
                    errs++;
                end
                else
                begin
                    want = pending_headings.pop_front();
                    if (result.heading_deg !== want.deg)
                    begin
                        $error("heading_deg: expected %0d, got %0d", want.deg,
                               result.heading_deg);
                        errs++;
                    end
                    if (result.heading_valid !== want.ok)
                    begin
                        $error("heading_valid: expected %0b, got %0b", want.ok,
                               result.heading_valid);
                        errs++;
                    end
                end
            end
            mismatches <= mismatches + errs;
            in_flight <= pending_headings.size();
        end
    end

endmodule

[tb/testbench.sv]
module testbench;
    import mh_pkg::*;

    localparam int CORDIC_STAGES = 16;
    localparam int SAMPLE_WIDTH  = 16;
    localparam int SETTLE_CYCLES = CORDIC_STAGES + 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 235;
    localparam int PHASES        = 8;

    localparam logic [15:0] MAG_MAX = 16'h7FFF;
    localparam logic [15:0] MAG_MIN = 16'h8000;
    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = 13'h0FFF;
    localparam logic [OFFSET_WIDTH-1:0] OFF_MIN = 13'h1000;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    cfg_index_t                     cfg_index;
    logic [OFFSET_WIDTH-1:0]        cfg_wdata;
    int                             mismatches;
    int                             in_flight;
    int                             send_idle_pct = 0;
    int                             recv_stall_pct = 0;
    logic                           recv_hold_req = 1'b0;
    logic signed [OFFSET_WIDTH-1:0] x_setting = '0;
    logic signed [OFFSET_WIDTH-1:0] y_setting = '0;

    mh_sample_if #(.W(SAMPLE_WIDTH)) sample_ch ();
    mh_heading_if                    result_ch ();

    magnetometer_heading #(
        .CORDIC_STAGES(CORDIC_STAGES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .sample   (sample_ch),
        .result   (result_ch)
    );

    heading_checker #(
        .STAGES(CORDIC_STAGES)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample    (sample_ch),
        .result    (result_ch),
        .mismatches(mismatches),
        .in_flight (in_flight)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("[magnetometer_heading] ERROR");
        $finish;
    end

    // A hold request keeps the result channel blocked long enough for the
    // pipeline to fill and push back on the sample channel.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (recv_hold_req)
            begin
                recv_hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_sample(input logic [15:0] mx, input logic [15:0] my);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.mag_x <= mx;
        sample_ch.mag_y <= my;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_offsets(input logic [OFFSET_WIDTH-1:0] xo,
                                 input logic [OFFSET_WIDTH-1:0] yo);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_X_OFFSET;
        cfg_wdata <= xo;
        @(posedge clk);
        cfg_index <= CFG_Y_OFFSET;
        cfg_wdata <= yo;
        @(posedge clk);
        cfg_we <= 1'b0;
        x_setting = xo;
        y_setting = yo;
    endtask

    // Full-range samples half of the time, plus samples whose corrected components
    // land near zero, on an axis or on a diagonal.
    task automatic random_sample();
        int          k;
        logic [15:0] mx;
        logic [15:0] my;
        mx = 16'($urandom);
        my = 16'($urandom);
        k = int'($urandom_range(20000)) - 10000;
        case ($urandom_range(9))
            5, 6:
            begin
                mx = 16'(int'($urandom_range(64)) - 32 - int'(y_setting));
                my = 16'(int'(x_setting) - int'($urandom_range(64)) + 32);
            end
            7: mx = 16'(-int'(y_setting));
            8: my = 16'(int'(x_setting));
            9:
            begin
                mx = 16'(k - int'(y_setting));
                my = $urandom_range(1) ? 16'(int'(x_setting) - k) : 16'(int'(x_setting) + k);
            end
            default: ;
        endcase
        send_sample(mx, my);
    endtask

    initial
    begin : stimulus
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_X_OFFSET;
        cfg_wdata <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.mag_x <= '0;
        sample_ch.mag_y <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_offsets('0, '0);
        send_sample(16'd0, 16'd0);
        send_sample(16'd0, 16'hFFFB);
        send_sample(16'd0, 16'd7);
        send_sample(16'd100, 16'd0);
        send_sample(16'hFF9C, 16'd0);
        send_sample(16'd50, 16'hFFCE);
        send_sample(16'd50, 16'd50);
        send_sample(16'hFFCE, 16'hFFCE);
        send_sample(MAG_MAX, MAG_MIN);
        send_sample(MAG_MIN, MAG_MAX);
        send_sample(MAG_MIN, MAG_MIN);
        send_sample(MAG_MAX, MAG_MAX);
        send_sample(16'd0, MAG_MIN);

        write_offsets(OFF_MAX, OFF_MIN);
        send_sample(16'd4096, 16'd4095);
        send_sample(MAG_MIN, MAG_MIN);
        send_sample(MAG_MAX, MAG_MIN);
        send_sample(16'd4096, 16'd0);
        send_sample(16'd0, 16'd4095);

        write_offsets(OFF_MIN, OFF_MAX);
        send_sample(16'hF001, 16'hF000);
        send_sample(MAG_MAX, MAG_MAX);
        send_sample(MAG_MIN, MAG_MIN);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                1: write_offsets(OFF_MAX, OFF_MAX);
                2: write_offsets(OFF_MIN, OFF_MIN);
                4: write_offsets('0, '0);
                default: write_offsets(13'($urandom), 13'($urandom));
            endcase
            send_idle_pct = (p % 4 == 1) ? 47 : (p % 4 == 3) ? 30 : 0;
            recv_stall_pct = (p % 4 == 2) ? 47 : (p % 4 == 3) ? 30 : 0;
            if (p == 4)
                recv_hold_req = 1'b1;
            repeat (PHASE_ITEMS) random_sample();
        end

        drain();
        if (mismatches == 0 && in_flight == 0)
            $display("[magnetometer_heading] OK");
        else
            $display("[magnetometer_heading] ERROR");
        $finish;
    end

endmodule
